>>> design/rsp_pkg.sv
// ----------------------------------------------------------------------------
// rsp_pkg
// Shared types and constants for the scalar instruction step block: opcode
// and function codes, data memory geometry and the memory request bundle.
// ----------------------------------------------------------------------------
package rsp_pkg;

	// data memory geometry: four byte-wide banks, one per address lane
	localparam int DMEM_BYTES = 4096;
	localparam int DMEM_AW    = $clog2(DMEM_BYTES);
	localparam int DMEM_LANES = 4;
	localparam int DMEM_ROWS  = DMEM_BYTES / DMEM_LANES;
	localparam int ROW_AW     = DMEM_AW - 2;

	// field and bus widths
	localparam int PC_W        = 12;
	localparam int WORD_W      = 32;
	localparam int REG_AW      = 5;
	localparam int GPR_COUNT   = 32;
	localparam int IN_TDATA_W  = 64;
	localparam int OUT_TDATA_W = 56;
	localparam int CFG_W       = 12;

	localparam logic [PC_W-1:0]   TARGET_MASK = 12'hFFC;
	localparam logic [PC_W-1:0]   PC_STEP     = 12'h004;
	localparam logic [REG_AW-1:0] GPR_RA      = 5'd31;
	localparam logic [REG_AW-1:0] GPR_ZERO    = 5'd0;

	// primary opcodes
	localparam logic [5:0] OPC_SPECIAL = 6'h00;
	localparam logic [5:0] OPC_J       = 6'h02;
	localparam logic [5:0] OPC_JAL     = 6'h03;
	localparam logic [5:0] OPC_BEQ     = 6'h04;
	localparam logic [5:0] OPC_BNE     = 6'h05;
	localparam logic [5:0] OPC_ADDI    = 6'h08;
	localparam logic [5:0] OPC_ANDI    = 6'h0C;
	localparam logic [5:0] OPC_ORI     = 6'h0D;
	localparam logic [5:0] OPC_LUI     = 6'h0F;
	localparam logic [5:0] OPC_COP0    = 6'h10;
	localparam logic [5:0] OPC_LW      = 6'h23;
	localparam logic [5:0] OPC_SW      = 6'h2B;

	// SPECIAL function codes
	localparam logic [5:0] FN_SLL   = 6'h00;
	localparam logic [5:0] FN_JR    = 6'h08;
	localparam logic [5:0] FN_BREAK = 6'h0D;
	localparam logic [5:0] FN_ADD   = 6'h20;

	// coprocessor sub-ops (rs field)
	localparam logic [4:0] COP_MF = 5'h00;
	localparam logic [4:0] COP_MT = 5'h04;

	// one data memory request from the execute stage
	typedef struct packed {
		logic               rd;
		logic               wr;
		logic [DMEM_AW-1:0] addr;
		logic [WORD_W-1:0]  wdata;
	} dmem_req_t;

endpackage

>>> design/rsp_dmem.sv
// ----------------------------------------------------------------------------
// rsp_data_ram
// Big-endian byte-addressed data memory built from four byte-lane banks, so
// an unaligned word touches each bank exactly once. Clears itself after reset.
// ----------------------------------------------------------------------------
module rsp_data_ram (
	input  logic                       clk,
	input  logic                       arst_n,
	input  rsp_pkg::dmem_req_t         req,
	output logic                       busy,
	output logic [rsp_pkg::WORD_W-1:0] ld_word
);
	import rsp_pkg::*;

	logic [ROW_AW-1:0] clr_row_q;
	logic              clr_busy_q;
	logic [1:0]        off_q;
	logic [DMEM_LANES-1:0][7:0] rd_bytes;

	// clearing sweep: one row of every bank per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_row_q  <= '0;
			clr_busy_q <= 1'b1;
		end else if (clr_busy_q) begin
			clr_row_q <= clr_row_q + ROW_AW'(1);
			if (clr_row_q == ROW_AW'(DMEM_ROWS - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	assign busy = clr_busy_q;

	// byte offset of the word, kept for the load rotate
	always_ff @(posedge clk) begin
		if (req.rd) begin
			off_q <= req.addr[1:0];
		end
	end

	for (genvar b = 0; b < DMEM_LANES; b++) begin : g_bank
		logic [7:0]        mem [DMEM_ROWS];
		logic [7:0]        rd_q;
		logic [1:0]        lane;
		logic [ROW_AW-1:0] row;
		logic [7:0]        wbyte;

		// which byte of the word lands in this bank, and on which row
		assign lane  = 2'(b) - req.addr[1:0];
		assign row   = req.addr[DMEM_AW-1:2] + ROW_AW'(2'(b) < req.addr[1:0]);
		assign wbyte = 8'(req.wdata >> {~lane, 3'b000});

		always_ff @(posedge clk) begin
			if (clr_busy_q) begin
				mem[clr_row_q] <= '0;
			end else if (req.wr) begin
				mem[row] <= wbyte;
			end
			if (req.rd) begin
				rd_q <= mem[row];
			end
		end

		assign rd_bytes[b] = rd_q;
	end

	// lowest address is the most significant byte
	assign ld_word = {rd_bytes[off_q], rd_bytes[off_q + 2'd1],
		rd_bytes[off_q + 2'd2], rd_bytes[off_q + 2'd3]};

endmodule

>>> design/rsp_scalar_instruction_step.sv
// ----------------------------------------------------------------------------
// rsp_scalar_instruction_step
// Small MIPS-like scalar core executing one instruction per request.
//
//  channel  | dir | handshake              | payload
//  ---------+-----+------------------------+----------------------------------
//  s_axis   | in  | s_axis_tvalid/tready   | instruction word, cop0 read data
//  m_axis   | out | m_axis_tvalid/tready   | fetch pc, cop0 write, break, illegal
//  cfg      | in  | cfg_valid/cfg_ready    | start pc
//
// One instruction per cycle sustained while the result register is not
// stalled. A request is registered, executed in the next cycle and lands in
// the result register; loads finish in a writeback stage after that, with
// operand forwarding so dependent instructions still issue back to back.
// After reset the data memory clears itself one row per lane bank per cycle,
// DMEM_BYTES/4 = 1024 rows, with s_axis_tready low. A stalled result
// register holds the execute stage; the config port is always ready.
// ----------------------------------------------------------------------------
module rsp_scalar_instruction_step (
	input  logic                            clk,
	input  logic                            arst_n,
	// [31:0] instruction_word, [63:32] cop0_read_data
	input  logic [rsp_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// [11:0] next_fetch_pc, [12] io_write_valid, [17:13] io_reg_index,
	// [49:18] io_write_data, [50] break_hit, [51] illegal_op, [55:52] zero
	output logic [rsp_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	input  logic [rsp_pkg::CFG_W-1:0]       cfg_data,
	input  logic                            cfg_valid,
	output logic                            cfg_ready
);
	import rsp_pkg::*;

	// register file
	logic [WORD_W-1:0]    gpr_mem [GPR_COUNT];
	logic [GPR_COUNT-1:0] gpr_vld_q;

	// execute stage
	logic              valid_s1;
	logic [WORD_W-1:0] ins_s1, cop_s1, rs_val_s1, rt_val_s1;
	logic              rs_hit_s1, rt_hit_s1;

	// writeback stage
	logic              wb_v_s2, wb_ld_s2;
	logic [REG_AW-1:0] wb_idx_s2;
	logic [WORD_W-1:0] wb_data_s2, s2_wdata;

	// result register and pc
	logic                   out_valid_q;
	logic [OUT_TDATA_W-1:0] out_data_q;
	logic [PC_W-1:0]        npc_q;

	logic in_acc, s1_adv, out_free, dmem_busy;
	dmem_req_t         dreq;
	logic [WORD_W-1:0] ld_word;

	// decode / execute
	logic [5:0]        opc, fn;
	logic [REG_AW-1:0] rs, rt, rd, sa, rs_in, rt_in;
	logic [15:0]       imm;
	logic [WORD_W-1:0] simm, a, b;
	logic [PC_W-1:0]   npc_adv, npc_nxt, btarget, jtarget;
	logic              wr_en_ex, ld_ex, st_ex, iwv_ex, brk_ex, bad_ex;
	logic [REG_AW-1:0] wr_idx_ex, io_idx_ex;
	logic [WORD_W-1:0] wr_data_ex, io_data_ex, mem_addr;

	assign cfg_ready     = 1'b1;
	assign out_free      = !out_valid_q || m_axis_tready;
	assign s1_adv        = valid_s1 && out_free;
	assign s_axis_tready = !dmem_busy && (!valid_s1 || out_free);
	assign in_acc        = s_axis_tvalid && s_axis_tready;

	assign rs_in = s_axis_tdata[25:21];
	assign rt_in = s_axis_tdata[20:16];

	// field split
	assign opc  = ins_s1[31:26];
	assign rs   = ins_s1[25:21];
	assign rt   = ins_s1[20:16];
	assign rd   = ins_s1[15:11];
	assign sa   = ins_s1[10:6];
	assign fn   = ins_s1[5:0];
	assign imm  = ins_s1[15:0];
	assign simm = {{16{imm[15]}}, imm};

	// operand forwarding from the writeback stage
	assign s2_wdata = wb_ld_s2 ? ld_word : wb_data_s2;
	assign a        = rs_hit_s1 ? s2_wdata : rs_val_s1;
	assign b        = rt_hit_s1 ? s2_wdata : rt_val_s1;

	// pc arithmetic; npc_q is the pc of the delay slot
	assign npc_adv  = npc_q + PC_STEP;
	assign btarget  = (npc_q + {simm[PC_W-3:0], 2'b00}) & TARGET_MASK;
	assign jtarget  = {ins_s1[PC_W-3:0], 2'b00};
	assign mem_addr = a + simm;

	always_comb begin
		wr_en_ex   = 1'b0;
		wr_idx_ex  = rt;
		wr_data_ex = '0;
		ld_ex      = 1'b0;
		st_ex      = 1'b0;
		npc_nxt    = npc_adv;
		iwv_ex     = 1'b0;
		io_idx_ex  = '0;
		io_data_ex = '0;
		brk_ex     = 1'b0;
		bad_ex     = 1'b0;
		case (opc)
			OPC_SPECIAL: begin
				case (fn)
					FN_SLL: begin
						wr_en_ex   = 1'b1;
						wr_idx_ex  = rd;
						wr_data_ex = b << sa;
					end
					FN_JR:    npc_nxt = a[PC_W-1:0] & TARGET_MASK;
					FN_BREAK: brk_ex = 1'b1;
					FN_ADD: begin
						wr_en_ex   = 1'b1;
						wr_idx_ex  = rd;
						wr_data_ex = a + b;
					end
					default:  bad_ex = 1'b1;
				endcase
			end
			OPC_J: npc_nxt = jtarget;
			OPC_JAL: begin
				wr_en_ex   = 1'b1;
				wr_idx_ex  = GPR_RA;
				wr_data_ex = WORD_W'(npc_adv);
				npc_nxt    = jtarget;
			end
			OPC_BEQ: begin
				if (a == b) begin
					npc_nxt = btarget;
				end
			end
			OPC_BNE: begin
				if (a != b) begin
					npc_nxt = btarget;
				end
			end
			OPC_ADDI: begin
				wr_en_ex   = 1'b1;
				wr_data_ex = a + simm;
			end
			OPC_ANDI: begin
				wr_en_ex   = 1'b1;
				wr_data_ex = a & {16'h0000, imm};
			end
			OPC_ORI: begin
				wr_en_ex   = 1'b1;
				wr_data_ex = a | {16'h0000, imm};
			end
			OPC_LUI: begin
				wr_en_ex   = 1'b1;
				wr_data_ex = {imm, 16'h0000};
			end
			OPC_COP0: begin
				if (rs == COP_MF) begin
					wr_en_ex   = 1'b1;
					wr_data_ex = cop_s1;
				end else if (rs == COP_MT) begin
					iwv_ex     = 1'b1;
					io_idx_ex  = rd;
					io_data_ex = b;
				end else begin
					bad_ex = 1'b1;
				end
			end
			OPC_LW: begin
				wr_en_ex = 1'b1;
				ld_ex    = 1'b1;
			end
			OPC_SW:  st_ex = 1'b1;
			default: bad_ex = 1'b1;
		endcase
		// writes to register zero are dropped
		if (wr_idx_ex == GPR_ZERO) begin
			wr_en_ex = 1'b0;
		end
	end

	// data memory access issued as the instruction leaves execute
	assign dreq.rd    = s1_adv && ld_ex;
	assign dreq.wr    = s1_adv && st_ex;
	assign dreq.addr  = mem_addr[DMEM_AW-1:0];
	assign dreq.wdata = b;

	rsp_data_ram u_dmem (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (dreq),
		.busy    (dmem_busy),
		.ld_word (ld_word)
	);

	// execute stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			rs_hit_s1 <= 1'b0;
			rt_hit_s1 <= 1'b0;
		end else begin
			if (in_acc) begin
				valid_s1 <= 1'b1;
			end else if (s1_adv) begin
				valid_s1 <= 1'b0;
			end
			// the instruction now in execute writes this register next cycle
			rs_hit_s1 <= in_acc && valid_s1 && wr_en_ex && (wr_idx_ex == rs_in);
			rt_hit_s1 <= in_acc && valid_s1 && wr_en_ex && (wr_idx_ex == rt_in);
		end
	end

	// request capture with register read; a held stage refreshes its operands
	always_ff @(posedge clk) begin
		if (in_acc) begin
			ins_s1 <= s_axis_tdata[WORD_W-1:0];
			cop_s1 <= s_axis_tdata[IN_TDATA_W-1:WORD_W];
			if (wb_v_s2 && wb_idx_s2 == rs_in) begin
				rs_val_s1 <= s2_wdata;
			end else begin
				rs_val_s1 <= gpr_vld_q[rs_in] ? gpr_mem[rs_in] : '0;
			end
			if (wb_v_s2 && wb_idx_s2 == rt_in) begin
				rt_val_s1 <= s2_wdata;
			end else begin
				rt_val_s1 <= gpr_vld_q[rt_in] ? gpr_mem[rt_in] : '0;
			end
		end else if (valid_s1 && !s1_adv) begin
			rs_val_s1 <= a;
			rt_val_s1 <= b;
		end
	end

	// writeback stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wb_v_s2 <= 1'b0;
		end else begin
			wb_v_s2 <= s1_adv && wr_en_ex;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			wb_idx_s2  <= wr_idx_ex;
			wb_data_s2 <= wr_data_ex;
			wb_ld_s2   <= ld_ex;
		end
	end

	// register file write; unwritten entries read as zero
	always_ff @(posedge clk) begin
		if (wb_v_s2) begin
			gpr_mem[wb_idx_s2] <= s2_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gpr_vld_q <= '0;
		end else if (wb_v_s2) begin
			gpr_vld_q[wb_idx_s2] <= 1'b1;
		end
	end

	// pc state and start pc load
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			npc_q <= PC_STEP;
		end else if (cfg_valid && cfg_ready) begin
			npc_q <= (cfg_data & TARGET_MASK) + PC_STEP;
		end else if (s1_adv) begin
			npc_q <= npc_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			out_data_q <= {4'h0, bad_ex, brk_ex, io_data_ex, io_idx_ex, iwv_ex, npc_q};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	// checks
	a_hit_has_source: assert property (@(posedge clk) disable iff (!arst_n)
		(rs_hit_s1 || rt_hit_s1) |-> wb_v_s2)
		else $error("forwarding hit without a writeback in flight");

	a_no_zero_write: assert property (@(posedge clk) disable iff (!arst_n)
		wb_v_s2 |-> (wb_idx_s2 != GPR_ZERO))
		else $error("writeback targets register zero");

	a_clear_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		dmem_busy |-> !s_axis_tready)
		else $error("request taken during memory clear");

	a_pc_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[1:0] == 2'b00))
		else $error("fetch pc not word aligned");

endmodule
